FILE: rtl/core/icmc_pkg.sv
`default_nettype none

package icmc_pkg;

   // one input request
   typedef struct packed {
      logic signed [11:0] temperature_sample;
      logic [9:0]         humidity_sample;
   } req_type;

   // one result
   typedef struct packed {
      logic [2:0]         mode;
      logic               fan_on;
      logic               light_on;
      logic               emergency_on;
      logic signed [11:0] avg_temperature;
      logic [15:0]        temp_err_above;
      logic [15:0]        temp_err_below;
      logic [1:0]         temp_direction;
      logic [15:0]        hum_err_above;
      logic [15:0]        hum_err_below;
      logic [1:0]         hum_direction;
   } rsp_type;

   typedef enum logic [2:0] {
      MODE_IDLE      = 3'd0,
      MODE_COOL      = 3'd1,
      MODE_WARM      = 3'd2,
      MODE_FAST_COOL = 3'd3,
      MODE_FAST_WARM = 3'd4,
      MODE_UNKNOWN   = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      DIR_BELOW = 2'd0,
      DIR_ABOVE = 2'd1,
      DIR_EQUAL = 2'd2
   } dir_type;

   typedef enum logic [3:0] {
      CSR_TEMP_NOMINAL = 4'd0,
      CSR_TEMP_MAX     = 4'd1,
      CSR_TEMP_MIN     = 4'd2,
      CSR_TEMP_GAIN    = 4'd3,
      CSR_HUM_NOMINAL  = 4'd4,
      CSR_HUM_MAX      = 4'd5,
      CSR_HUM_MIN      = 4'd6,
      CSR_HUM_GAIN     = 4'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_LAUNCH   = 3'd1,
      ST_MUL_WAIT = 3'd2,
      ST_DIV_WAIT = 3'd3,
      ST_RESP     = 3'd4
   } state_type;

   // evaluation jobs, run in this order
   typedef enum logic [2:0] {
      JOB_TEMP_AVG = 3'd0,
      JOB_HUM_AVG  = 3'd1,
      JOB_T_ABOVE  = 3'd2,
      JOB_T_BELOW  = 3'd3,
      JOB_H_ABOVE  = 3'd4,
      JOB_H_BELOW  = 3'd5
   } job_type;

   localparam logic signed [11:0] TEMP_NOMINAL_RST = 12'sd375;
   localparam logic signed [11:0] TEMP_MAX_RST     = 12'sd385;
   localparam logic signed [11:0] TEMP_MIN_RST     = 12'sd365;
   localparam logic [15:0]        GAIN_RST         = 16'd256;
   localparam logic [9:0]         HUM_NOMINAL_RST  = 10'd550;
   localparam logic [9:0]         HUM_MAX_RST      = 10'd650;
   localparam logic [9:0]         HUM_MIN_RST      = 10'd450;

   localparam logic [15:0] ERR_SAT = 16'hFFFF;

   // serial multiplier: (distance * 100) by gain, one gain bit per cycle
   localparam int MUL_A_W   = 19;
   localparam int MUL_B_W   = 16;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // serial divider: one quotient bit per cycle
   localparam int DIV_STEPS = 16;
   localparam int DIV_REM_W = 20;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

`default_nettype wire

FILE: rtl/core/icmc_mul.sv
`default_nettype none

module icmc_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [icmc_pkg::MUL_A_W-1:0]       mcand,
   input  logic [icmc_pkg::MUL_B_W-1:0]       mplier,
   output logic                               done,
   output logic [icmc_pkg::PROD_W-1:0]        product
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [icmc_pkg::MUL_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [icmc_pkg::PROD_W-1:0]        acc_ff, acc_in;
   logic [icmc_pkg::PROD_W-1:0]        mcand_ff, mcand_in;
   logic [icmc_pkg::MUL_B_W-1:0]       mplier_ff, mplier_in;

   // shift-add, multiplier bits lsb first
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = icmc_pkg::MUL_CNT_W'(icmc_pkg::MUL_B_W - 1);
         acc_in    = '0;
         mcand_in  = icmc_pkg::PROD_W'(mcand);
         mplier_in = mplier;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[icmc_pkg::PROD_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[icmc_pkg::MUL_B_W-1:1]};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

FILE: rtl/core/icmc_div.sv
`default_nettype none

module icmc_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [icmc_pkg::DIV_REM_W-1:0]     num_hi,
   input  logic [icmc_pkg::DIV_STEPS-1:0]     num_lo,
   input  logic [icmc_pkg::DIV_REM_W-1:0]     den,
   output logic                               done,
   output logic [icmc_pkg::DIV_STEPS-1:0]     quot
);

   // num_hi must be below den so the quotient fits DIV_STEPS bits

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [icmc_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [icmc_pkg::DIV_REM_W-1:0]     rem_ff, rem_in;
   logic [icmc_pkg::DIV_STEPS-1:0]     lo_ff, lo_in;
   logic [icmc_pkg::DIV_REM_W-1:0]     den_ff, den_in;
   logic [icmc_pkg::DIV_STEPS-1:0]     quot_ff, quot_in;
   logic [icmc_pkg::DIV_REM_W:0]       trial;
   logic [icmc_pkg::DIV_REM_W:0]       diff;
   logic                               fits;

   assign trial = {rem_ff, lo_ff[icmc_pkg::DIV_STEPS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   // restoring division, one bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = icmc_pkg::DIV_CNT_W'(icmc_pkg::DIV_STEPS - 1);
         rem_in  = num_hi;
         lo_in   = num_lo;
         den_in  = den;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[icmc_pkg::DIV_REM_W-1:0] : trial[icmc_pkg::DIV_REM_W-1:0];
         lo_in   = {lo_ff[icmc_pkg::DIV_STEPS-2:0], 1'b0};
         quot_in = {quot_ff[icmc_pkg::DIV_STEPS-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

FILE: rtl/core/incubator_climate_mode_controller_unit.sv
// incubator climate mode controller
// req channel (valid/ready) carries one temperature and one humidity sample per
// request; rsp channel (valid/ready) returns exactly one result per request, in
// order, holding the current mode, drives, average temperature and errors.
// csr port: write-only, csr_index 0..7 selects a setting, other indexes ignored;
// write only while no request is in flight.
// the first SAMPLES_PER_AVERAGE requests after a clear are summed and answered
// through the ST_RESP state; no new request is taken until that result is posted.
// the next request is an evaluating one: its samples are dropped, both averages
// come from the serial divider, then four percent errors each take a serial
// multiply and a serial divide; the divide is skipped when the quotient would
// saturate, and both are skipped (error saturated) when the span is zero.
// reset restores the default settings, clears sums and averages, mode idle,
// errors zero, directions equal, and empties the result register.
// a stalled receiver holds the result register; one more request may be taken
// and worked on meanwhile, its result waits until the register frees up.
`default_nettype none

module incubator_climate_mode_controller_unit #(
   parameter int SAMPLES_PER_AVERAGE = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  icmc_pkg::req_type     req_data,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output icmc_pkg::rsp_type     rsp_data,
   // settings
   input  logic                  csr_we,
   input  logic [3:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   localparam logic [3:0]                       AVG_COUNT = 4'(SAMPLES_PER_AVERAGE);
   localparam logic [icmc_pkg::DIV_REM_W-1:0]   AVG_DEN   =
      icmc_pkg::DIV_REM_W'(SAMPLES_PER_AVERAGE);

   // settings registers
   logic signed [11:0] temp_nominal_ff, temp_max_ff, temp_min_ff;
   logic [15:0]        temp_gain_ff, hum_gain_ff;
   logic [9:0]         hum_nominal_ff, hum_max_ff, hum_min_ff;

   // control and held state
   icmc_pkg::state_type state_ff, state_in;
   icmc_pkg::job_type   job_ff, job_in;
   logic [3:0]          count_ff, count_in;
   logic [14:0]         temp_sum_ff, temp_sum_in;
   logic [13:0]         hum_sum_ff, hum_sum_in;
   logic signed [11:0]  avg_temp_ff, avg_temp_in;
   logic [9:0]          avg_hum_ff, avg_hum_in;
   icmc_pkg::mode_type  mode_ff, mode_in;
   logic [15:0]         err_ff [4];
   logic [15:0]         err_in [4];
   icmc_pkg::dir_type   dir_t_ff, dir_t_in;
   icmc_pkg::dir_type   dir_h_ff, dir_h_in;
   logic                rsp_valid_ff, rsp_valid_in;
   icmc_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // arithmetic unit hookups
   logic                                  mul_start, mul_done;
   logic [icmc_pkg::PROD_W-1:0]           mul_product;
   logic                                  div_start, div_done;
   logic [icmc_pkg::DIV_REM_W-1:0]        div_num_hi, div_den;
   logic [icmc_pkg::DIV_STEPS-1:0]        div_num_lo, div_quot;

   // operand selection for the error jobs
   logic signed [12:0]  op_avg, op_nom, op_lim, dist_diff, span_diff;
   logic [11:0]         dist_mag, span;
   logic [15:0]         op_gain;
   logic [icmc_pkg::MUL_A_W-1:0] dist19, dist_x100;
   logic [icmc_pkg::DIV_REM_W-1:0] err_den;
   logic                err_over;
   logic [1:0]          err_sel;
   logic                job_is_temp;

   // average dividends
   logic [14:0]         temp_mag;
   logic [icmc_pkg::DIV_STEPS-1:0] avg_num_lo;

   // evaluation results
   icmc_pkg::mode_type  next_mode;
   icmc_pkg::dir_type   next_dir_t, next_dir_h;
   logic                advance;

   assign job_is_temp = (job_ff == icmc_pkg::JOB_T_ABOVE) ||
                        (job_ff == icmc_pkg::JOB_T_BELOW);
   assign err_sel     = 2'(job_ff - icmc_pkg::JOB_T_ABOVE);

   always_comb begin
      if (job_is_temp) begin
         op_avg  = {avg_temp_ff[11], avg_temp_ff};
         op_nom  = {temp_nominal_ff[11], temp_nominal_ff};
         op_gain = temp_gain_ff;
      end else begin
         op_avg  = {3'b000, avg_hum_ff};
         op_nom  = {3'b000, hum_nominal_ff};
         op_gain = hum_gain_ff;
      end
      case (job_ff)
         icmc_pkg::JOB_T_ABOVE: op_lim = {temp_max_ff[11], temp_max_ff};
         icmc_pkg::JOB_T_BELOW: op_lim = {temp_min_ff[11], temp_min_ff};
         icmc_pkg::JOB_H_ABOVE: op_lim = {3'b000, hum_max_ff};
         icmc_pkg::JOB_H_BELOW: op_lim = {3'b000, hum_min_ff};
         default:               op_lim = op_nom;
      endcase
   end

   // distance and span magnitudes fit 12 bits for 12-bit signed operands
   assign dist_diff = op_avg - op_nom;
   assign span_diff = op_lim - op_nom;
   assign dist_mag  = dist_diff[12] ? 12'(-dist_diff) : dist_diff[11:0];
   assign span      = span_diff[12] ? 12'(-span_diff) : span_diff[11:0];

   // distance times 100 as 64 + 32 + 4
   assign dist19    = icmc_pkg::MUL_A_W'(dist_mag);
   assign dist_x100 = (dist19 << 6) + (dist19 << 5) + (dist19 << 2);

   // err = floor(gain * dist * 100 / (span * 256)); span * 256 is the divisor
   assign err_den  = {span, 8'h00};
   // quotient beyond 16 bits when the top product bits reach the divisor
   assign err_over = ({1'b0, mul_product[icmc_pkg::PROD_W-1:icmc_pkg::DIV_STEPS]} >= err_den);

   // sums are divided by magnitude, sign put back afterward (truncation toward zero)
   assign temp_mag   = temp_sum_ff[14] ? (~temp_sum_ff + 15'd1) : temp_sum_ff;
   assign avg_num_lo = (job_ff == icmc_pkg::JOB_TEMP_AVG) ?
                       icmc_pkg::DIV_STEPS'(temp_mag) : icmc_pkg::DIV_STEPS'(hum_sum_ff);

   // mode priority: below min, above max, cool band, warm band, idle
   always_comb begin
      if (avg_temp_ff < temp_min_ff) begin
         next_mode = icmc_pkg::MODE_FAST_WARM;
      end else if (avg_temp_ff > temp_max_ff) begin
         next_mode = icmc_pkg::MODE_FAST_COOL;
      end else if ((avg_temp_ff == temp_max_ff) || (avg_temp_ff > temp_nominal_ff)) begin
         next_mode = icmc_pkg::MODE_COOL;
      end else if ((avg_temp_ff == temp_min_ff) || (avg_temp_ff < temp_nominal_ff)) begin
         next_mode = icmc_pkg::MODE_WARM;
      end else begin
         next_mode = icmc_pkg::MODE_IDLE;
      end

      if (avg_temp_ff < temp_nominal_ff) begin
         next_dir_t = icmc_pkg::DIR_BELOW;
      end else if (avg_temp_ff > temp_nominal_ff) begin
         next_dir_t = icmc_pkg::DIR_ABOVE;
      end else begin
         next_dir_t = icmc_pkg::DIR_EQUAL;
      end

      if (avg_hum_ff < hum_nominal_ff) begin
         next_dir_h = icmc_pkg::DIR_BELOW;
      end else if (avg_hum_ff > hum_nominal_ff) begin
         next_dir_h = icmc_pkg::DIR_ABOVE;
      end else begin
         next_dir_h = icmc_pkg::DIR_EQUAL;
      end
   end

   // sequencer: accumulate, or run the six evaluation jobs, then post the result
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      count_in     = count_ff;
      temp_sum_in  = temp_sum_ff;
      hum_sum_in   = hum_sum_ff;
      avg_temp_in  = avg_temp_ff;
      avg_hum_in   = avg_hum_ff;
      mode_in      = mode_ff;
      err_in       = err_ff;
      dir_t_in     = dir_t_ff;
      dir_h_in     = dir_h_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      div_num_hi   = '0;
      div_num_lo   = avg_num_lo;
      div_den      = AVG_DEN;
      advance      = 1'b0;

      // result taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         icmc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff < AVG_COUNT) begin
                  // accumulate, temperature sign-extended into the 15-bit sum
                  temp_sum_in = temp_sum_ff + {{3{req_data.temperature_sample[11]}},
                                               req_data.temperature_sample};
                  hum_sum_in  = hum_sum_ff + {4'b0000, req_data.humidity_sample};
                  count_in    = count_ff + 4'd1;
                  state_in    = icmc_pkg::ST_RESP;
               end else begin
                  // evaluating request: its samples are dropped
                  job_in   = icmc_pkg::JOB_TEMP_AVG;
                  state_in = icmc_pkg::ST_LAUNCH;
               end
            end
         end

         icmc_pkg::ST_LAUNCH: begin
            if ((job_ff == icmc_pkg::JOB_TEMP_AVG) || (job_ff == icmc_pkg::JOB_HUM_AVG)) begin
               div_start = 1'b1;
               state_in  = icmc_pkg::ST_DIV_WAIT;
            end else begin
               // both averages are settled by the first error job
               if (job_ff == icmc_pkg::JOB_T_ABOVE) begin
                  mode_in  = next_mode;
                  dir_t_in = next_dir_t;
                  dir_h_in = next_dir_h;
               end
               if (span == 12'd0) begin
                  // zero span saturates, even at zero distance
                  err_in[err_sel] = icmc_pkg::ERR_SAT;
                  advance         = 1'b1;
               end else begin
                  mul_start = 1'b1;
                  state_in  = icmc_pkg::ST_MUL_WAIT;
               end
            end
         end

         icmc_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               if (err_over) begin
                  err_in[err_sel] = icmc_pkg::ERR_SAT;
                  advance         = 1'b1;
               end else begin
                  div_start  = 1'b1;
                  div_num_hi = icmc_pkg::DIV_REM_W'(
                     mul_product[icmc_pkg::PROD_W-1:icmc_pkg::DIV_STEPS]);
                  div_num_lo = mul_product[icmc_pkg::DIV_STEPS-1:0];
                  div_den    = err_den;
                  state_in   = icmc_pkg::ST_DIV_WAIT;
               end
            end
         end

         icmc_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               advance = 1'b1;
               case (job_ff)
                  icmc_pkg::JOB_TEMP_AVG: begin
                     avg_temp_in = temp_sum_ff[14] ? 12'(~div_quot + 16'd1) : div_quot[11:0];
                  end
                  icmc_pkg::JOB_HUM_AVG: begin
                     avg_hum_in = div_quot[9:0];
                  end
                  default: begin
                     err_in[err_sel] = div_quot;
                  end
               endcase
            end
         end

         icmc_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.mode            = mode_ff;
               rsp_data_in.fan_on          = (mode_ff == icmc_pkg::MODE_COOL) ||
                                             (mode_ff == icmc_pkg::MODE_FAST_COOL);
               rsp_data_in.light_on        = (mode_ff == icmc_pkg::MODE_WARM) ||
                                             (mode_ff == icmc_pkg::MODE_FAST_WARM);
               rsp_data_in.emergency_on    = (mode_ff == icmc_pkg::MODE_FAST_COOL) ||
                                             (mode_ff == icmc_pkg::MODE_FAST_WARM);
               rsp_data_in.avg_temperature = avg_temp_ff;
               rsp_data_in.temp_err_above  = err_ff[0];
               rsp_data_in.temp_err_below  = err_ff[1];
               rsp_data_in.temp_direction  = dir_t_ff;
               rsp_data_in.hum_err_above   = err_ff[2];
               rsp_data_in.hum_err_below   = err_ff[3];
               rsp_data_in.hum_direction   = dir_h_ff;
               state_in                    = icmc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = icmc_pkg::ST_IDLE;
         end
      endcase

      // next job, or clear the sums after the last one
      if (advance) begin
         if (job_ff == icmc_pkg::JOB_H_BELOW) begin
            temp_sum_in = '0;
            hum_sum_in  = '0;
            count_in    = '0;
            state_in    = icmc_pkg::ST_RESP;
         end else begin
            job_in   = icmc_pkg::job_type'(job_ff + 3'd1);
            state_in = icmc_pkg::ST_LAUNCH;
         end
      end
   end

   // settings writes; unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_nominal_ff <= icmc_pkg::TEMP_NOMINAL_RST;
         temp_max_ff     <= icmc_pkg::TEMP_MAX_RST;
         temp_min_ff     <= icmc_pkg::TEMP_MIN_RST;
         temp_gain_ff    <= icmc_pkg::GAIN_RST;
         hum_nominal_ff  <= icmc_pkg::HUM_NOMINAL_RST;
         hum_max_ff      <= icmc_pkg::HUM_MAX_RST;
         hum_min_ff      <= icmc_pkg::HUM_MIN_RST;
         hum_gain_ff     <= icmc_pkg::GAIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            icmc_pkg::CSR_TEMP_NOMINAL: temp_nominal_ff <= csr_wdata[11:0];
            icmc_pkg::CSR_TEMP_MAX:     temp_max_ff     <= csr_wdata[11:0];
            icmc_pkg::CSR_TEMP_MIN:     temp_min_ff     <= csr_wdata[11:0];
            icmc_pkg::CSR_TEMP_GAIN:    temp_gain_ff    <= csr_wdata;
            icmc_pkg::CSR_HUM_NOMINAL:  hum_nominal_ff  <= csr_wdata[9:0];
            icmc_pkg::CSR_HUM_MAX:      hum_max_ff      <= csr_wdata[9:0];
            icmc_pkg::CSR_HUM_MIN:      hum_min_ff      <= csr_wdata[9:0];
            icmc_pkg::CSR_HUM_GAIN:     hum_gain_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // control and held state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= icmc_pkg::ST_IDLE;
         job_ff       <= icmc_pkg::JOB_TEMP_AVG;
         count_ff     <= '0;
         temp_sum_ff  <= '0;
         hum_sum_ff   <= '0;
         avg_temp_ff  <= '0;
         avg_hum_ff   <= '0;
         mode_ff      <= icmc_pkg::MODE_IDLE;
         err_ff       <= '{default: '0};
         dir_t_ff     <= icmc_pkg::DIR_EQUAL;
         dir_h_ff     <= icmc_pkg::DIR_EQUAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         count_ff     <= count_in;
         temp_sum_ff  <= temp_sum_in;
         hum_sum_ff   <= hum_sum_in;
         avg_temp_ff  <= avg_temp_in;
         avg_hum_ff   <= avg_hum_in;
         mode_ff      <= mode_in;
         err_ff       <= err_in;
         dir_t_ff     <= dir_t_in;
         dir_h_ff     <= dir_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   icmc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (dist_x100),
      .mplier  (op_gain),
      .done    (mul_done),
      .product (mul_product)
   );

   icmc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_hi (div_num_hi),
      .num_lo (div_num_lo),
      .den    (div_den),
      .done   (div_done),
      .quot   (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/icmc_checker.sv
`default_nettype none

module icmc_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  icmc_pkg::rsp_type     rsp_data
);

   // requests accepted but not yet answered
   logic [1:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pending_in = pending_ff + 2'd1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // no result without a request behind it
   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 2'd0))
      else $error("result without an outstanding request");

   // reset empties the result register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed or dropped");

   // drives agree: never heat and cool together, emergency only with a drive, mode known
   a_drive_agree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!(rsp_data.fan_on && rsp_data.light_on) &&
                     (!rsp_data.emergency_on || rsp_data.fan_on || rsp_data.light_on) &&
                     (rsp_data.mode != icmc_pkg::MODE_UNKNOWN)))
      else $error("inconsistent drive outputs");

endmodule

bind incubator_climate_mode_controller_unit icmc_checker u_icmc_checker (.*);

`default_nettype wire
